### src/klex_pkg.sv
// klex_pkg: shared types, token kind codes and the keyword spelling table
// for the keyword lexer; used by keyword_lexer_byte_stream and klex_checker
// depends on nothing
package klex_pkg;

    // saturating counter width for line, column and token byte counts
    localparam int CNT_BITS = 16;
    localparam int OUT_BITS = 16;
    localparam int NUM_KW   = 20;
    localparam int KW_CHARS = 9;
    localparam int RES_MAX  = 3;
    localparam int Q_DEPTH  = 4;
    localparam int Q_PTR_BITS = $clog2(Q_DEPTH);
    localparam int Q_CNT_BITS = $clog2(Q_DEPTH + 1);

    typedef logic [CNT_BITS-1:0] cnt_t;
    typedef logic [5:0]          kind_t;

    // token kinds
    localparam kind_t K_END     = 6'd0;
    localparam kind_t K_ASSIGN  = 6'd1;
    localparam kind_t K_COMMA   = 6'd2;
    localparam kind_t K_DOT     = 6'd3;
    localparam kind_t K_PLUS    = 6'd4;
    localparam kind_t K_MINUS   = 6'd5;
    localparam kind_t K_STAR    = 6'd6;
    localparam kind_t K_DIV     = 6'd7;
    localparam kind_t K_PERCENT = 6'd8;
    localparam kind_t K_STRING  = 6'd9;
    localparam kind_t K_NUMBER  = 6'd10;
    localparam kind_t K_IDENT   = 6'd11;
    localparam kind_t K_COMMENT = 6'd12;
    localparam kind_t K_ERROR   = 6'd13;
    localparam kind_t K_KW0     = 6'd14;
    localparam kind_t K_LAST    = 6'd33;

    localparam cnt_t CNT_MAX = {CNT_BITS{1'b1}};
    localparam cnt_t CNT_ONE = cnt_t'(1);

    typedef struct packed {
        kind_t               kind;
        logic [OUT_BITS-1:0] line;
        logic [OUT_BITS-1:0] column;
        logic [OUT_BITS-1:0] length;
        logic                err;
        logic                last;
    } tok_t;

    // keyword spellings, right justified in each entry
    localparam logic [8*KW_CHARS-1:0] KW_TEXT [NUM_KW] = '{
        "start", "load", "clean", "split", "train", "evaluate", "show", "save",
        "create", "with", "into", "ratio", "path", "metric", "epochs", "type",
        "model", "data", "visualize", "plot"
    };
    localparam logic [3:0] KW_LEN [NUM_KW] = '{
        4'd5, 4'd4, 4'd5, 4'd5, 4'd5, 4'd8, 4'd4, 4'd4,
        4'd6, 4'd4, 4'd4, 4'd5, 4'd4, 4'd6, 4'd6, 4'd4,
        4'd5, 4'd4, 4'd9, 4'd4
    };

    // character at a position of a keyword, zero past its end
    function automatic logic [7:0] kw_char(input logic [4:0] k, input logic [3:0] pos);
        logic [3:0] len;
        logic [3:0] idx;
        len = KW_LEN[k];
        idx = len - pos - 4'd1;
        if (pos < len)
            return KW_TEXT[k][idx*8 +: 8];
        else
            return 8'd0;
    endfunction

    function automatic cnt_t sat_inc(input cnt_t x);
        return (x == CNT_MAX) ? x : x + CNT_ONE;
    endfunction

    function automatic cnt_t sub0(input cnt_t a, input cnt_t b);
        return (a >= b) ? a - b : '0;
    endfunction

    function automatic tok_t make_tok(
        input kind_t kind,
        input cnt_t  line,
        input cnt_t  col_after,
        input cnt_t  consumed,
        input cnt_t  len,
        input logic  err
    );
        tok_t t;
        t.kind   = kind;
        t.line   = OUT_BITS'(line);
        t.column = OUT_BITS'(sub0(col_after, consumed));
        t.length = OUT_BITS'(len);
        t.err    = err;
        t.last   = 1'b0;
        return t;
    endfunction

endpackage

### src/keyword_lexer_byte_stream.sv
// keyword_lexer_byte_stream: byte-serial lexer with keyword matching
// one scan step per accepted request, results queued and drained one per cycle while tok_stall is low
// depends on klex_pkg
//
//   channel | direction | handshake           | payload
//   --------+-----------+---------------------+------------------------------------------
//   src     | in        | src_valid/src_stall | source_byte, end_of_source
//   tok     | out       | tok_valid/tok_stall | token_kind, token_line, token_column,
//           |           |                     | token_length, error_seen, last_of_run
//
// a src request is scanned in the cycle it is accepted: the scan state updates at
// that edge and its zero to three tokens land in a four-entry result queue
// tokens leave the queue at one per cycle while tok_stall is low, so the sustained rate is
// one request per cycle while each request yields at most one token, and set by the
// queue drain when requests yield more
// src_stall is high while the queue holds two or more tokens, i.e. when it could
// not take a full three-token burst; it comes from a register only
// tok_stall holds the queue head in place; src keeps flowing until the queue holds two or more tokens
// rst_n clears the scan state (line and column one, idle mode) and empties the queue
module keyword_lexer_byte_stream (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    src_valid,
    output logic                    src_stall,
    input  logic [7:0]              source_byte,
    input  logic                    end_of_source,
    output logic                    tok_valid,
    input  logic                    tok_stall,
    output klex_pkg::kind_t         token_kind,
    output logic [15:0]             token_line,
    output logic [15:0]             token_column,
    output logic [15:0]             token_length,
    output logic                    error_seen,
    output logic                    last_of_run
);
    import klex_pkg::*;

    // scan modes
    localparam logic [3:0] M_IDLE    = 4'd0;
    localparam logic [3:0] M_INT     = 4'd1;
    localparam logic [3:0] M_DOT     = 4'd2;
    localparam logic [3:0] M_FRAC    = 4'd3;
    localparam logic [3:0] M_IDENT   = 4'd4;
    localparam logic [3:0] M_STRING  = 4'd5;
    localparam logic [3:0] M_COMMENT = 4'd6;
    localparam logic [3:0] M_SLASH   = 4'd7;

    // scan state
    logic [3:0]        mode_reg,  mode_next;
    logic              qsgl_reg,  qsgl_next;
    cnt_t              line_reg,  line_next;
    cnt_t              col_reg,   col_next;
    cnt_t              tlen_reg,  tlen_next;
    logic [NUM_KW-1:0] kw_reg,    kw_next;
    logic              err_reg,   err_next;

    // result queue
    tok_t                  q_reg [Q_DEPTH];
    logic [Q_PTR_BITS-1:0] wr_reg, rd_reg;
    logic [Q_CNT_BITS-1:0] cnt_reg, cnt_next;

    tok_t        res [RES_MAX];
    logic [1:0]  nres;
    logic        src_acc, tok_acc;
    logic        do_close, do_idle;
    logic        is_digit, is_alpha, is_ws, is_ctrl, close_quote;
    kind_t       id_kind, punct_kind;
    logic        is_punct;
    logic [NUM_KW-1:0] kw_match;
    logic [NUM_KW-1:0] kw_first;

    assign src_acc   = src_valid && !src_stall;
    assign tok_acc   = tok_valid && !tok_stall;
    assign src_stall = (cnt_reg > Q_CNT_BITS'(Q_DEPTH - RES_MAX));

    // byte classes
    assign is_digit = (source_byte >= "0") && (source_byte <= "9");
    assign is_alpha = ((source_byte >= "a") && (source_byte <= "z"))
                   || ((source_byte >= "A") && (source_byte <= "Z"))
                   || (source_byte == "_");
    assign is_ws    = (source_byte == " ") || (source_byte == 8'h09) || (source_byte == 8'h0D);
    assign is_ctrl  = (source_byte < 8'd32) || (source_byte == 8'd127);
    assign close_quote = qsgl_reg ? (source_byte == 8'h27) : (source_byte == 8'h22);

    always_comb
    begin
        is_punct   = 1'b1;
        punct_kind = K_ERROR;
        unique case (source_byte)
            "=":     punct_kind = K_ASSIGN;
            ",":     punct_kind = K_COMMA;
            ".":     punct_kind = K_DOT;
            "+":     punct_kind = K_PLUS;
            "-":     punct_kind = K_MINUS;
            "*":     punct_kind = K_STAR;
            "%":     punct_kind = K_PERCENT;
            default: is_punct = 1'b0;
        endcase
    end

    // keyword candidate narrowing; at identifier start the mask holds the keywords whose first character matches
    always_comb
    begin
        for (int k = 0; k < NUM_KW; k++)
        begin
            kw_match[k] = (tlen_reg < cnt_t'(KW_CHARS))
                       && (kw_char(5'(k), 4'(tlen_reg)) == source_byte);
            kw_first[k] = (kw_char(5'(k), 4'd0) == source_byte);
        end
    end

    // identifier kind: lowest keyword still a candidate whose spelling ends here
    always_comb
    begin
        id_kind = K_IDENT;
        for (int k = NUM_KW - 1; k >= 0; k--)
        begin
            if (kw_reg[k] && (tlen_reg <= cnt_t'(KW_CHARS))
                && (kw_char(5'(k), 4'(tlen_reg)) == 8'd0))
                id_kind = K_KW0 + 6'(k);
        end
    end

    // one scan step: close the open token if needed, then restart from idle or end
    always_comb
    begin
        mode_next = mode_reg;
        qsgl_next = qsgl_reg;
        line_next = line_reg;
        col_next  = col_reg;
        tlen_next = tlen_reg;
        kw_next   = kw_reg;
        err_next  = err_reg;
        nres      = 2'd0;
        res       = '{default: '0};
        do_close  = 1'b0;
        do_idle   = 1'b0;

        if (end_of_source)
        begin
            do_close = 1'b1;
        end
        else
        begin
            unique case (mode_reg)
                M_INT:
                begin
                    if (is_digit)
                    begin
                        col_next  = sat_inc(col_reg);
                        tlen_next = sat_inc(tlen_reg);
                    end
                    else if (source_byte == ".")
                    begin
                        col_next  = sat_inc(col_reg);
                        mode_next = M_DOT;
                    end
                    else
                    begin
                        do_close = 1'b1;
                        do_idle  = 1'b1;
                    end
                end
                M_DOT:
                begin
                    // digit after the dot: the dot joins the number
                    if (is_digit)
                    begin
                        col_next  = sat_inc(col_reg);
                        tlen_next = sat_inc(sat_inc(tlen_reg));
                        mode_next = M_FRAC;
                    end
                    else
                    begin
                        do_close = 1'b1;
                        do_idle  = 1'b1;
                    end
                end
                M_FRAC:
                begin
                    if (is_digit)
                    begin
                        col_next  = sat_inc(col_reg);
                        tlen_next = sat_inc(tlen_reg);
                    end
                    else
                    begin
                        do_close = 1'b1;
                        do_idle  = 1'b1;
                    end
                end
                M_IDENT:
                begin
                    if (is_alpha || is_digit)
                    begin
                        kw_next   = kw_reg & kw_match;
                        col_next  = sat_inc(col_reg);
                        tlen_next = sat_inc(tlen_reg);
                    end
                    else
                    begin
                        do_close = 1'b1;
                        do_idle  = 1'b1;
                    end
                end
                M_STRING:
                begin
                    if (close_quote)
                    begin
                        col_next  = sat_inc(col_reg);
                        tlen_next = sat_inc(tlen_reg);
                        res[nres] = make_tok(K_STRING, line_reg, col_next, tlen_next,
                                             sub0(tlen_next, cnt_t'(2)), err_reg);
                        nres      = nres + 2'd1;
                        mode_next = M_IDLE;
                    end
                    else
                    begin
                        // newline in a string: column restarts at one, then counts it
                        if (source_byte == 8'h0A)
                        begin
                            line_next = sat_inc(line_reg);
                            col_next  = sat_inc(CNT_ONE);
                        end
                        else
                        begin
                            col_next = sat_inc(col_reg);
                        end
                        tlen_next = sat_inc(tlen_reg);
                    end
                end
                M_COMMENT:
                begin
                    if (source_byte == 8'h0A)
                    begin
                        do_close = 1'b1;
                        do_idle  = 1'b1;
                    end
                    else
                    begin
                        col_next  = sat_inc(col_reg);
                        tlen_next = sat_inc(tlen_reg);
                    end
                end
                M_SLASH:
                begin
                    if (source_byte == "/")
                    begin
                        col_next  = sat_inc(col_reg);
                        tlen_next = cnt_t'(2);
                        mode_next = M_COMMENT;
                    end
                    else
                    begin
                        do_close = 1'b1;
                        do_idle  = 1'b1;
                    end
                end
                default:
                begin
                    // idle and unused codes
                    do_idle = 1'b1;
                end
            endcase
        end

        // flush the open token; counters are still those before this byte
        if (do_close)
        begin
            unique case (mode_reg)
                M_INT, M_FRAC:
                begin
                    res[nres] = make_tok(K_NUMBER, line_reg, col_reg, tlen_reg,
                                         tlen_reg, err_next);
                    nres      = nres + 2'd1;
                end
                M_DOT:
                begin
                    res[nres] = make_tok(K_NUMBER, line_reg, sub0(col_reg, CNT_ONE),
                                         tlen_reg, tlen_reg, err_next);
                    nres      = nres + 2'd1;
                    res[nres] = make_tok(K_DOT, line_reg, col_reg, CNT_ONE, CNT_ONE,
                                         err_next);
                    nres      = nres + 2'd1;
                end
                M_IDENT:
                begin
                    res[nres] = make_tok(id_kind, line_reg, col_reg, tlen_reg,
                                         tlen_reg, err_next);
                    nres      = nres + 2'd1;
                end
                M_COMMENT:
                begin
                    res[nres] = make_tok(K_COMMENT, line_reg, col_reg, tlen_reg,
                                         sub0(tlen_reg, cnt_t'(2)), err_next);
                    nres      = nres + 2'd1;
                end
                M_SLASH:
                begin
                    res[nres] = make_tok(K_DIV, line_reg, col_reg, CNT_ONE, CNT_ONE,
                                         err_next);
                    nres      = nres + 2'd1;
                end
                M_STRING:
                begin
                    // unterminated string at end of text
                    if (end_of_source)
                    begin
                        err_next  = 1'b1;
                        res[nres] = make_tok(K_ERROR, line_reg, col_reg, tlen_reg,
                                             sub0(tlen_reg, CNT_ONE), 1'b1);
                        nres      = nres + 2'd1;
                    end
                end
                default:
                begin
                end
            endcase
            mode_next = M_IDLE;
        end

        if (end_of_source)
        begin
            res[nres] = make_tok(K_END, line_reg, col_reg, '0, '0, err_next);
            nres      = nres + 2'd1;
            // back to reset state for the next text
            mode_next = M_IDLE;
            qsgl_next = 1'b0;
            line_next = CNT_ONE;
            col_next  = CNT_ONE;
            tlen_next = '0;
            kw_next   = '0;
            err_next  = 1'b0;
        end
        else if (do_idle)
        begin
            mode_next = M_IDLE;
            col_next  = sat_inc(col_reg);
            priority if (source_byte == 8'h0A)
            begin
                line_next = sat_inc(line_reg);
                col_next  = CNT_ONE;
            end
            else if (is_ws)
            begin
            end
            else if (is_ctrl)
            begin
                err_next = 1'b1;
            end
            else if (is_punct)
            begin
                res[nres] = make_tok(punct_kind, line_reg, col_next, CNT_ONE, CNT_ONE,
                                     err_next);
                nres      = nres + 2'd1;
            end
            else if (source_byte == "/")
            begin
                mode_next = M_SLASH;
                tlen_next = CNT_ONE;
            end
            else if ((source_byte == 8'h22) || (source_byte == 8'h27))
            begin
                mode_next = M_STRING;
                qsgl_next = (source_byte == 8'h27);
                tlen_next = CNT_ONE;
            end
            else if (is_digit)
            begin
                mode_next = M_INT;
                tlen_next = CNT_ONE;
            end
            else if (is_alpha)
            begin
                mode_next = M_IDENT;
                tlen_next = CNT_ONE;
                kw_next   = kw_first;
            end
            else
            begin
                // unknown printable or high byte
                err_next  = 1'b1;
                res[nres] = make_tok(K_ERROR, line_reg, col_next, CNT_ONE, CNT_ONE,
                                     1'b1);
                nres      = nres + 2'd1;
            end
        end

        if (nres != 2'd0)
            res[nres - 2'd1].last = 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= M_IDLE;
            qsgl_reg <= 1'b0;
            line_reg <= CNT_ONE;
            col_reg  <= CNT_ONE;
            tlen_reg <= '0;
            kw_reg   <= '0;
            err_reg  <= 1'b0;
        end
        else if (src_acc)
        begin
            mode_reg <= mode_next;
            qsgl_reg <= qsgl_next;
            line_reg <= line_next;
            col_reg  <= col_next;
            tlen_reg <= tlen_next;
            kw_reg   <= kw_next;
            err_reg  <= err_next;
        end
    end

    // result queue bookkeeping
    always_comb
    begin
        cnt_next = cnt_reg;
        if (src_acc)
            cnt_next = cnt_next + Q_CNT_BITS'(nres);
        if (tok_acc)
            cnt_next = cnt_next - Q_CNT_BITS'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            cnt_reg <= cnt_next;
            if (src_acc)
                wr_reg <= wr_reg + Q_PTR_BITS'(nres);
            if (tok_acc)
                rd_reg <= rd_reg + Q_PTR_BITS'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (src_acc)
        begin
            for (int i = 0; i < RES_MAX; i++)
            begin
                if (2'(i) < nres)
                    q_reg[wr_reg + Q_PTR_BITS'(i)] <= res[i];
            end
        end
    end

    assign tok_valid    = (cnt_reg != '0);
    assign token_kind   = q_reg[rd_reg].kind;
    assign token_line   = q_reg[rd_reg].line;
    assign token_column = q_reg[rd_reg].column;
    assign token_length = q_reg[rd_reg].length;
    assign error_seen   = q_reg[rd_reg].err;
    assign last_of_run  = q_reg[rd_reg].last;

endmodule

### src/klex_checker.sv
// klex_checker: port-level checks on keyword_lexer_byte_stream, with its bind
// depends on klex_pkg and keyword_lexer_byte_stream
module klex_checker (
    input logic            clk,
    input logic            rst_n,
    input logic            tok_valid,
    input logic            tok_stall,
    input klex_pkg::kind_t token_kind,
    input logic [15:0]     token_line,
    input logic [15:0]     token_column,
    input logic [15:0]     token_length,
    input logic            error_seen,
    input logic            last_of_run
);
    import klex_pkg::*;

    // a stalled token request holds
    a_tok_hold: assert property (@(posedge clk) disable iff (!rst_n)
        tok_valid && tok_stall |=> tok_valid && $stable(token_kind)
            && $stable(token_line) && $stable(token_column)
            && $stable(token_length) && $stable(error_seen) && $stable(last_of_run))
        else $error("token request changed while stalled");

    a_kind_range: assert property (@(posedge clk) disable iff (!rst_n)
        tok_valid |-> token_kind <= K_LAST)
        else $error("token kind out of range");

    a_line_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        tok_valid |-> token_line != 16'd0)
        else $error("token line is zero");

    // end token always closes its run
    a_end_last: assert property (@(posedge clk) disable iff (!rst_n)
        tok_valid && token_kind == K_END |-> last_of_run)
        else $error("end token not last of run");

    a_error_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        tok_valid && token_kind == K_ERROR |-> error_seen)
        else $error("error token without sticky error");

endmodule

bind keyword_lexer_byte_stream klex_checker u_klex_checker (.*);
